// ----- hw/rtl/sb2da_pkg.sv -----
// Shared constants and controller/datapath interface types for the decimal text converter.
`default_nettype none
package sb2da_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W         = STEPS * BITS_PER_STEP;
  // decimal digits needed for an unsigned VALUE_WIDTH-bit magnitude
  localparam int NDIG          = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W         = NDIG * 4;
  localparam int PTR_W         = $clog2(NDIG);
  localparam int CNT_W         = $clog2(STEPS);
  localparam int TDATA_W       = ((VALUE_WIDTH + 7) / 8) * 8;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic step;
    logic find;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic neg;
    logic out_free;
    logic ptr_zero;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sb2da_dp.sv -----
// Datapath: magnitude, shift-and-add-3 BCD conversion, digit pointer and output register.
`default_nettype none
module sb2da_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sb2da_pkg::dp_cmd_t            cmd,
  output sb2da_pkg::dp_sts_t                 sts,
  input  wire logic [sb2da_pkg::TDATA_W-1:0] in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,
  output logic                               out_tlast
);
  import sb2da_pkg::*;

  logic [PAD_W-1:0]       mag_r, mag_nxt, mag_step;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt, bcd_step;
  logic                   neg_r, neg_nxt;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt, first_nz;
  logic                   ovalid_r, ovalid_nxt;
  logic [7:0]             ochar_r, ochar_nxt;
  logic                   olast_r, olast_nxt;
  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] val_mag;
  logic [3:0]             cur_digit;

  assign val     = in_tdata[VALUE_WIDTH-1:0];
  assign val_mag = val[VALUE_WIDTH-1] ? (~val + 1'b1) : val;

  // Several double-dabble bit steps per cycle.
  always_comb begin
    logic [BCD_W-1:0] b;
    logic [PAD_W-1:0] m;
    b = bcd_r;
    m = mag_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (b[d*4 +: 4] >= 4'd5) b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
      end
      b = {b[BCD_W-2:0], m[PAD_W-1]};
      m = {m[PAD_W-2:0], 1'b0};
    end
    bcd_step = b;
    mag_step = m;
  end

  // Highest nonzero digit; zero keeps one digit.
  always_comb begin
    first_nz = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (bcd_r[d*4 +: 4] != 4'd0) first_nz = PTR_W'(d);
    end
  end

  assign cur_digit = bcd_r[ptr_r*4 +: 4];

  always_comb begin
    mag_nxt    = mag_r;
    bcd_nxt    = bcd_r;
    neg_nxt    = neg_r;
    ptr_nxt    = ptr_r;
    ochar_nxt  = ochar_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r & ~out_tready;
    if (cmd.load) begin
      neg_nxt = val[VALUE_WIDTH-1];
      mag_nxt = PAD_W'(val_mag);
      bcd_nxt = '0;
    end
    if (cmd.step) begin
      mag_nxt = mag_step;
      bcd_nxt = bcd_step;
    end
    if (cmd.find) ptr_nxt = first_nz;
    if (cmd.emit_sign) begin
      ovalid_nxt = 1'b1;
      ochar_nxt  = CHAR_MINUS;
      olast_nxt  = 1'b0;
    end
    if (cmd.emit_digit) begin
      ovalid_nxt = 1'b1;
      ochar_nxt  = CHAR_ZERO + {4'd0, cur_digit};
      olast_nxt  = (ptr_r == '0);
      ptr_nxt    = ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
    mag_r   <= mag_nxt;
    bcd_r   <= bcd_nxt;
    neg_r   <= neg_nxt;
    ptr_r   <= ptr_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign sts.neg      = neg_r;
  assign sts.out_free = ~ovalid_r | out_tready;
  assign sts.ptr_zero = (ptr_r == '0);

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;

endmodule
`default_nettype wire

// ----- hw/rtl/sb2da_ctrl.sv -----
// Controller: sequences load, conversion steps, digit search and character output.
`default_nettype none
module sb2da_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output sb2da_pkg::dp_cmd_t      cmd,
  input  wire sb2da_pkg::dp_sts_t sts
);
  import sb2da_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) state_nxt = S_FIND;
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = sts.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.ptr_zero) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/signed_binary_to_decimal_ascii_top.sv -----
// Top level: signed integer to decimal ASCII text, one character per output item.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata[31:0] = value (signed)
//  out_    | out | out_tvalid/tready  | out_tdata[7:0] = character, out_tlast = last
//
// An item is accepted, converted 4 bits per cycle through the shift-and-add-3
// unit, searched for its leading digit, then emitted one character at a time:
// 1 to 11 characters.
// Output stalls hold the controller in its emit states; the next item is taken
// while the final character still waits in the output register.
// Reset clears the controller and the output valid flag only.
`default_nettype none
module signed_binary_to_decimal_ascii_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [sb2da_pkg::TDATA_W-1:0] in_tdata,   // value
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [7:0]                         out_tdata,  // character
  output logic                               out_tlast
);
  import sb2da_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sb2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sb2da_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
